/* hdl/psa_pkg.sv */
`timescale 1ns / 1ps

package psa_pkg;

    localparam int IDX_W      = 10;
    localparam int VAL_W      = 32;
    localparam int AXES       = 3;
    localparam int WORD_W     = AXES * VAL_W;
    localparam int CMD_W      = 2;
    localparam int DEF_POINTS = 1024;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD = 2'd0,
        CMD_PAIR = 2'd1,
        CMD_READ = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RD_A,
        ST_UPD_A,
        ST_UPD_B,
        ST_READ,
        ST_RESP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic rd_en;
        logic rd_sel_b;
        logic wr_en;
        logic wr_sel_b;
        logic wr_load;
        logic out_load;
    } dp_ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_busy;
    } dp_stat_t;

    // Adds or subtracts two signed 32-bit values and clamps to the 32-bit range.
    function automatic logic [VAL_W-1:0] sat_addsub(input logic [VAL_W-1:0] a,
                                                    input logic [VAL_W-1:0] b,
                                                    input logic sub);
        logic [VAL_W:0] s;
        logic [VAL_W-1:0] r;
        if (sub)
            s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
        else
            s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1])
            r = s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        else
            r = s[VAL_W-1:0];
        return r;
    endfunction

endpackage

/* hdl/psa_ctrl.sv */
`timescale 1ns / 1ps

module psa_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [psa_pkg::CMD_W-1:0]     cmd,
    input  logic [psa_pkg::IDX_W-1:0]     index_a,
    input  logic [psa_pkg::IDX_W-1:0]     index_b,
    output psa_pkg::dp_ctrl_t             ctrl,
    input  psa_pkg::dp_stat_t             stat
);

    psa_pkg::state_t state_reg;
    psa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= psa_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            psa_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (cmd)
                        psa_pkg::CMD_LOAD: state_next = psa_pkg::ST_LOAD;
                        // A pair on one entry cancels out and needs no work.
                        psa_pkg::CMD_PAIR:
                            state_next = (index_a == index_b) ? psa_pkg::ST_IDLE
                                                              : psa_pkg::ST_RD_A;
                        psa_pkg::CMD_READ: state_next = psa_pkg::ST_READ;
                        default:           state_next = psa_pkg::ST_IDLE;
                    endcase
                end
            end
            psa_pkg::ST_LOAD:  state_next = psa_pkg::ST_IDLE;
            psa_pkg::ST_RD_A:  state_next = psa_pkg::ST_UPD_A;
            psa_pkg::ST_UPD_A: state_next = psa_pkg::ST_UPD_B;
            psa_pkg::ST_UPD_B: state_next = psa_pkg::ST_IDLE;
            psa_pkg::ST_READ:  state_next = psa_pkg::ST_RESP;
            psa_pkg::ST_RESP:
            begin
                if (!stat.out_busy)
                    state_next = psa_pkg::ST_IDLE;
            end
            default:           state_next = psa_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl     = '0;
        in_stall = 1'b1;
        case (state_reg)
            psa_pkg::ST_IDLE:
            begin
                in_stall     = 1'b0;
                ctrl.capture = in_valid;
            end
            psa_pkg::ST_LOAD:
            begin
                ctrl.wr_en   = 1'b1;
                ctrl.wr_load = 1'b1;
            end
            psa_pkg::ST_RD_A:
            begin
                ctrl.rd_en = 1'b1;
            end
            psa_pkg::ST_UPD_A:
            begin
                ctrl.wr_en    = 1'b1;
                ctrl.rd_en    = 1'b1;
                ctrl.rd_sel_b = 1'b1;
            end
            psa_pkg::ST_UPD_B:
            begin
                ctrl.wr_en    = 1'b1;
                ctrl.wr_sel_b = 1'b1;
            end
            psa_pkg::ST_READ:
            begin
                ctrl.rd_en = 1'b1;
            end
            psa_pkg::ST_RESP:
            begin
                ctrl.out_load = !stat.out_busy;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

endmodule

/* hdl/psa_datapath.sv */
`timescale 1ns / 1ps

module psa_datapath #(
    parameter int POINTS = psa_pkg::DEF_POINTS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic                                cfg_data,
    input  logic [psa_pkg::IDX_W-1:0]           index_a,
    input  logic [psa_pkg::IDX_W-1:0]           index_b,
    input  logic signed [psa_pkg::VAL_W-1:0]    value_x,
    input  logic signed [psa_pkg::VAL_W-1:0]    value_y,
    input  logic signed [psa_pkg::VAL_W-1:0]    value_z,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [psa_pkg::IDX_W-1:0]           read_index,
    output logic signed [psa_pkg::VAL_W-1:0]    accel_x,
    output logic signed [psa_pkg::VAL_W-1:0]    accel_y,
    output logic signed [psa_pkg::VAL_W-1:0]    accel_z,
    input  psa_pkg::dp_ctrl_t                   ctrl,
    output psa_pkg::dp_stat_t                   stat
);

    localparam int ADDR_W = (POINTS > 1) ? $clog2(POINTS) : 1;
    localparam int EXT_W  = (ADDR_W > psa_pkg::IDX_W) ? ADDR_W : psa_pkg::IDX_W;
    localparam int VW     = psa_pkg::VAL_W;

    logic [psa_pkg::WORD_W-1:0] mem [POINTS];

    logic                      three_d_reg;
    logic                      out_valid_reg;
    logic [psa_pkg::IDX_W-1:0] ia_reg;
    logic [psa_pkg::IDX_W-1:0] ib_reg;
    logic [VW-1:0]             vx_reg;
    logic [VW-1:0]             vy_reg;
    logic [VW-1:0]             vz_reg;
    logic [psa_pkg::WORD_W-1:0] rd_data_reg;
    logic [psa_pkg::IDX_W-1:0] rdi_reg;
    logic [VW-1:0]             ax_reg;
    logic [VW-1:0]             ay_reg;
    logic [VW-1:0]             az_reg;

    logic                      a_in_range;
    logic                      b_in_range;
    logic [EXT_W-1:0]          a_ext;
    logic [EXT_W-1:0]          b_ext;
    logic [ADDR_W-1:0]         rd_addr;
    logic [ADDR_W-1:0]         wr_addr;
    logic                      wr_go;
    logic [psa_pkg::WORD_W-1:0] wr_data;
    logic [VW-1:0]             new_x;
    logic [VW-1:0]             new_y;
    logic [VW-1:0]             new_z;

    assign a_in_range = (32'(ia_reg) < 32'(POINTS));
    assign b_in_range = (32'(ib_reg) < 32'(POINTS));
    assign a_ext      = EXT_W'(ia_reg);
    assign b_ext      = EXT_W'(ib_reg);
    assign rd_addr    = ctrl.rd_sel_b ? b_ext[ADDR_W-1:0] : a_ext[ADDR_W-1:0];
    assign wr_addr    = ctrl.wr_sel_b ? b_ext[ADDR_W-1:0] : a_ext[ADDR_W-1:0];
    assign wr_go      = ctrl.wr_en && (ctrl.wr_sel_b ? b_in_range : a_in_range);

    // Entry A takes plus delta, entry B minus delta; 2-D mode keeps z.
    assign new_x = psa_pkg::sat_addsub(rd_data_reg[VW-1:0], vx_reg, ctrl.wr_sel_b);
    assign new_y = psa_pkg::sat_addsub(rd_data_reg[2*VW-1:VW], vy_reg, ctrl.wr_sel_b);
    assign new_z = three_d_reg
                 ? psa_pkg::sat_addsub(rd_data_reg[3*VW-1:2*VW], vz_reg, ctrl.wr_sel_b)
                 : rd_data_reg[3*VW-1:2*VW];
    assign wr_data = ctrl.wr_load ? {vz_reg, vy_reg, vx_reg} : {new_z, new_y, new_x};

    always_ff @(posedge clk)
    begin
        if (wr_go)
            mem[wr_addr] <= wr_data;
        if (ctrl.rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            ia_reg <= index_a;
            ib_reg <= index_b;
            vx_reg <= value_x;
            vy_reg <= value_y;
            vz_reg <= value_z;
        end
        if (ctrl.out_load)
        begin
            rdi_reg <= ia_reg;
            ax_reg  <= a_in_range ? rd_data_reg[VW-1:0] : '0;
            ay_reg  <= a_in_range ? rd_data_reg[2*VW-1:VW] : '0;
            az_reg  <= (a_in_range && three_d_reg) ? rd_data_reg[3*VW-1:2*VW] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            three_d_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                three_d_reg <= cfg_data;
            if (ctrl.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign stat.out_busy = out_valid_reg && out_stall;
    assign out_valid     = out_valid_reg;
    assign read_index    = rdi_reg;
    assign accel_x       = ax_reg;
    assign accel_y       = ay_reg;
    assign accel_z       = az_reg;

endmodule

/* hdl/pairwise_scatter_accumulate.sv */
`timescale 1ns / 1ps
// A read item's result passes the captured index, the registered table read and the output
// register, held back only while an earlier result waits in the stalled output register.
// No new item is taken until the last is through: a pair on two entries steps through RD_A,
// UPD_A and UPD_B, a load through LOAD, a read through READ and RESP plus any output wait,
// a pair on one entry none; all set by the single write port and the registered table read.
// Reset: rst_n clears the controller, the output valid and sets three_dimensional to 1;
// the entry table holds nothing defined until each entry is loaded.

module pairwise_scatter_accumulate #(
    parameter int POINTS = psa_pkg::DEF_POINTS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration: the three_dimensional mode bit.
    input  logic                                cfg_write,
    input  logic                                cfg_data,
    // Input items.
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [psa_pkg::CMD_W-1:0]           cmd,
    input  logic [psa_pkg::IDX_W-1:0]           index_a,
    input  logic [psa_pkg::IDX_W-1:0]           index_b,
    input  logic signed [psa_pkg::VAL_W-1:0]    value_x,
    input  logic signed [psa_pkg::VAL_W-1:0]    value_y,
    input  logic signed [psa_pkg::VAL_W-1:0]    value_z,
    // Result items, one per read item.
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [psa_pkg::IDX_W-1:0]           read_index,
    output logic signed [psa_pkg::VAL_W-1:0]    accel_x,
    output logic signed [psa_pkg::VAL_W-1:0]    accel_y,
    output logic signed [psa_pkg::VAL_W-1:0]    accel_z
);

    // The controller sequences one item at a time. A pair item reads entry A,
    // writes A back while reading B, then writes B. Because the next item is
    // only taken once the last write has landed, no forwarding is needed.
    // A finished result sits in the output register, so load and pair items
    // keep flowing while it waits; a read item waits for that register.
    psa_pkg::dp_ctrl_t ctrl;
    psa_pkg::dp_stat_t stat;

    psa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .index_a  (index_a),
        .index_b  (index_b),
        .ctrl     (ctrl),
        .stat     (stat)
    );

    // The datapath holds the entry table, the saturating adders, the mode bit
    // and the output register.
    psa_datapath #(
        .POINTS (POINTS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .index_a    (index_a),
        .index_b    (index_b),
        .value_x    (value_x),
        .value_y    (value_y),
        .value_z    (value_z),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_index (read_index),
        .accel_x    (accel_x),
        .accel_y    (accel_y),
        .accel_z    (accel_z),
        .ctrl       (ctrl),
        .stat       (stat)
    );

endmodule
